// ----- rtl/core/ppm_pulse_train_decoder_top_macros.svh -----
// Assertion macros for the PPM decoder checker.
// Depends on nothing; included by the checker file.
`ifndef PPM_PULSE_TRAIN_DECODER_TOP_MACROS_SVH
`define PPM_PULSE_TRAIN_DECODER_TOP_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset
`define PPD_ASSERT_CLK(lbl, c, r, prop, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);

// Clocked assertion on the block clock and reset
`define PPD_ASSERT(lbl, prop, msg) \
	`PPD_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ----- rtl/core/ppd_pkg.sv -----
// Shared types, codes and constants of the PPM pulse train decoder.
// No dependencies; imported by every module of the block.
package ppd_pkg;

	localparam int NUM_CHANNELS_DEF = 8;

	localparam int TS_W   = 32;
	localparam int VAL_W  = 16;
	localparam int IDX_W  = 4;
	localparam int SEL_W  = 3;
	localparam int RSL_W  = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [VAL_W-1:0] SYNC_THR_RST   = 16'd3000;
	localparam logic [RSL_W-1:0] READY_SLOT_RST = 3'd3;
	localparam logic [VAL_W-1:0] CHAN_RST       = 16'd1500;
	localparam logic [VAL_W-1:0] THROTTLE_RST   = 16'd1000;
	localparam int               THROTTLE_SLOT  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THR   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_SLOT = 1'd1;

	typedef enum logic [1:0] {
		OP_EDGE = 2'd0,
		OP_READ = 2'd1,
		OP_POLL = 2'd2
	} op_t;

	typedef struct packed {
		logic             sync;
		logic             written;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic             ready;
	} res_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	function automatic logic [VAL_W-1:0] chan_rst_val(input int unsigned idx);
		return (idx == THROTTLE_SLOT) ? THROTTLE_RST : CHAN_RST;
	endfunction

endpackage

// ----- rtl/core/ppd_chan_store.sv -----
// Channel width store: synchronous memory with a registered read.
// Per-entry valid bits give the reset widths; depends on ppd_pkg.
module ppd_chan_store import ppd_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int AW = $clog2(NUM_CHANNELS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_ctl_t         ctl,
	input  logic [AW-1:0]    wr_addr,
	input  logic [VAL_W-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0]        mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	logic [VAL_W-1:0]        rdata_q;
	logic                    rvld_q;
	logic [AW-1:0]           raddr_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
			rvld_q  <= vld_q[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// unwritten entries read as their reset width
	assign rd_data = rvld_q ? rdata_q : chan_rst_val(int'(raddr_q));

endmodule

// ----- rtl/core/ppd_edge_ctl.sv -----
// Edge interval, slot counter and new-data flag for the PPM decoder.
// Builds the per-request result and store access; depends on ppd_pkg.
module ppd_edge_ctl import ppd_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int AW = $clog2(NUM_CHANNELS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       op,
	input  logic [TS_W-1:0]  timestamp_us,
	input  logic [SEL_W-1:0] channel_select,
	input  logic [VAL_W-1:0] sync_thr,
	input  logic [RSL_W-1:0] ready_slot,
	output res_t             res,
	output logic             rd_hit,
	output mem_ctl_t         ctl,
	output logic [AW-1:0]    wr_addr,
	output logic [VAL_W-1:0] wr_data,
	output logic [AW-1:0]    rd_addr
);

	localparam int CW    = $clog2(NUM_CHANNELS + 1);
	localparam int CMP_W = (CW > RSL_W) ? CW : RSL_W;
	localparam logic [CW-1:0] NC_C = CW'(NUM_CHANNELS);

	logic [TS_W-1:0] last_q;
	logic [CW-1:0]   cnt_q;
	logic            flag_q;

	logic [TS_W-1:0] width;
	logic            is_edge;
	logic            is_read;
	logic            is_poll;
	logic            sync;
	logic            in_rng;
	logic            written;
	logic            hit_rdy;

	always_comb begin
		is_edge = (op == OP_EDGE);
		is_read = (op == OP_READ);
		is_poll = (op == OP_POLL);
		width   = timestamp_us - last_q;
		sync    = width > TS_W'(sync_thr);
		in_rng  = cnt_q < NC_C;
		written = is_edge && !sync && in_rng;
		hit_rdy = is_edge && !sync && (CMP_W'(cnt_q) == CMP_W'(ready_slot));
		rd_hit  = is_read && (int'(channel_select) < NUM_CHANNELS);

		res         = '0;
		res.sync    = is_edge && sync;
		res.written = written;
		res.idx     = (is_edge && !sync) ? IDX_W'(cnt_q) : '0;
		res.val     = written ? width[VAL_W-1:0] : '0;
		res.ready   = is_poll && flag_q;

		ctl.wr_en = accept && written;
		ctl.rd_en = accept && rd_hit;
		wr_addr   = cnt_q[AW-1:0];
		wr_data   = width[VAL_W-1:0];
		rd_addr   = AW'(channel_select);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			cnt_q  <= '0;
			flag_q <= 1'b0;
		end else if (accept) begin
			if (is_edge) begin
				last_q <= timestamp_us;
				if (sync) begin
					cnt_q <= '0;
				end else if (in_rng) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (hit_rdy) begin
				flag_q <= 1'b1;
			end else if (is_poll) begin
				flag_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/ppm_pulse_train_decoder_top.sv -----
// PPM pulse train decoder, top level.
// Channels: request input (op, timestamp_us, channel_select) and result output,
// both valid/ready; a plain write port sets the sync threshold and ready slot.
// Every request gives exactly one result, in order.
// Op edge: interval since the last edge; above the threshold it marks sync and
// clears the slot counter, otherwise it is stored in the current slot if in range.
// Op read: returns one stored channel width. Op poll: returns and clears the
// new-data flag.
// A result is registered in stage one, then in the output register. Throughput:
// one request per cycle while the result is not stalled, set by the subtract,
// compare and store write in the edge stage and the store's one read port.
// Stage one holds the registered store read; stage two is the output register,
// so a request is still taken while a result waits, until both stages are full.
// Reset: threshold 3000, ready slot 3, counter, flag and edge time zero, all
// channels 1500 with throttle slot 2 at 1000; no clearing pass is needed.
// Receiver stall: the result holds unchanged; in_ready drops when both stages
// are occupied.
// Depends on ppd_pkg, ppd_edge_ctl and ppd_chan_store.
module ppm_pulse_train_decoder_top import ppd_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [TS_W-1:0]       timestamp_us,
	input  logic [SEL_W-1:0]      channel_select,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  sync_detected,
	output logic                  slot_written,
	output logic [IDX_W-1:0]      slot_index,
	output logic [VAL_W-1:0]      channel_value,
	output logic                  frame_ready
);

	localparam int AW = $clog2(NUM_CHANNELS);

	logic [VAL_W-1:0] thr_q;
	logic [RSL_W-1:0] rsl_q;

	logic             acc;
	logic             adv;
	res_t             res;
	logic             rd_hit;
	mem_ctl_t         ctl;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;

	logic             v_s1;
	res_t             res_s1;
	logic             hit_s1;
	res_t             res_mux;
	logic             v_s2;
	res_t             res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= SYNC_THR_RST;
			rsl_q <= READY_SLOT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_THR:   thr_q <= cfg_data;
				REG_READY_SLOT: rsl_q <= cfg_data[RSL_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv;
	assign acc      = in_valid && in_ready;

	ppd_edge_ctl #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.AW(AW)
	) u_edge (
		.clk(clk),
		.arst_n(arst_n),
		.accept(acc),
		.op(op),
		.timestamp_us(timestamp_us),
		.channel_select(channel_select),
		.sync_thr(thr_q),
		.ready_slot(rsl_q),
		.res(res),
		.rd_hit(rd_hit),
		.ctl(ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr)
	);

	ppd_chan_store #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_comb begin
		res_mux = res_s1;
		if (hit_s1) begin
			res_mux.val = rd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
			hit_s1 <= rd_hit;
		end
		if (adv) begin
			res_s2 <= res_mux;
		end
	end

	assign out_valid     = v_s2;
	assign sync_detected = res_s2.sync;
	assign slot_written  = res_s2.written;
	assign slot_index    = res_s2.idx;
	assign channel_value = res_s2.val;
	assign frame_ready   = res_s2.ready;

endmodule

// ----- rtl/core/ppd_checker.sv -----
// Port-level checker for the PPM decoder, bound to the top level.
// Depends on ppd_pkg and ppm_pulse_train_decoder_top_macros.svh.
`include "ppm_pulse_train_decoder_top_macros.svh"

module ppd_checker import ppd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             sync_detected,
	input logic             slot_written,
	input logic [IDX_W-1:0] slot_index,
	input logic [VAL_W-1:0] channel_value,
	input logic             frame_ready
);

	// hold a stalled result
	`PPD_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(sync_detected) && $stable(slot_written) && $stable(slot_index) && $stable(channel_value) && $stable(frame_ready), "stalled result changed")

	`PPD_ASSERT(a_sync, out_valid && sync_detected |-> !slot_written && slot_index == '0 && channel_value == '0 && !frame_ready, "sync result carries slot data")

	`PPD_ASSERT(a_poll, out_valid && frame_ready |-> !sync_detected && !slot_written && slot_index == '0 && channel_value == '0, "poll result carries edge data")

	`PPD_ASSERT(a_beyond, out_valid && !sync_detected && !slot_written && slot_index != '0 |-> channel_value == '0, "unstored edge carries a width")

endmodule

bind ppm_pulse_train_decoder_top ppd_checker u_ppd_checker (.*);
